// ===== rtl/frc_pkg.sv =====
// types and constants shared by the fifo replacement cache cell chain and its top level
// depends on nothing

package frc_pkg;

  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int FLD_W = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int DEL_OUT_W = 5;

  typedef enum logic [2:0] {
    REQ_PUT      = 3'd0,
    REQ_FIND     = 3'd1,
    REQ_DEL_KEY  = 3'd2,
    REQ_DEL_SLOT = 3'd3,
    REQ_READ_KEY = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_e_t;

  typedef struct packed {
    logic             valid;
    req_e_t           req;
    logic [FLD_W-1:0] key;
    logic [FLD_W-1:0] data;
    logic [IDX_W-1:0] slot;
    logic             found;
    logic [IDX_W-1:0] slot_out;
    logic [FLD_W-1:0] data_out;
    logic [FLD_W-1:0] key_out;
    logic [CNT_W-1:0] count;
  } pkt_t;

endpackage

// ===== rtl/fifo_replacement_cache.sv =====
// top level of the fifo replacement cache: request issue, chain of slot cells, result skid
// depends on frc_pkg and frc_cell
//
// channel | dir | tdata                                   | tuser
// in_     | in  | key_in, data_in, slot_in                | req_type
// out_    | out | found, slot_out, data_out, key_out,     | -
//         |     | deleted_count, hit_total, miss_total    |
//
// a word walks the chain one cell per cycle, then moves through the result hold register
// into the output register; one word is in the chain at a time, and the next word is
// taken the cycle after the previous result has moved into the output register
// reset clears all slots, the write pointer and both counters at once
// a stalled output holds its word; one finished result can wait behind it

module fifo_replacement_cache #(
  parameter int DEPTH      = 16,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // key_in[31:0], data_in[31:0], slot_in[3:0], zero pad
  input  logic [2:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // found, slot_out[3:0], data_out[31:0], key_out[31:0],
                                   // deleted_count[4:0], hit_total[31:0], miss_total[31:0],
                                   // zero pad
);
  import frc_pkg::*;

  localparam int KW = (KEY_WIDTH < FLD_W) ? KEY_WIDTH : FLD_W;
  localparam int DW = (DATA_WIDTH < FLD_W) ? DATA_WIDTH : FLD_W;
  localparam int SW = $clog2(DEPTH);
  localparam logic [FLD_W-1:0] KMASK = (KW >= FLD_W) ? {FLD_W{1'b1}} :
                                       FLD_W'((64'd1 << KW) - 64'd1);
  localparam logic [FLD_W-1:0] DMASK = (DW >= FLD_W) ? {FLD_W{1'b1}} :
                                       FLD_W'((64'd1 << DW) - 64'd1);

  pkt_t               chain [DEPTH+1];
  pkt_t               head;
  logic [DEPTH-1:0]   chain_v;
  logic               in_acc;
  logic               move;
  logic               busy_r, busy_nxt;
  logic [SW-1:0]      wp_r, wp_nxt;
  logic [FLD_W-1:0]   hit_r, hit_nxt;
  logic [FLD_W-1:0]   miss_r, miss_nxt;
  pkt_t               res_r;
  logic               res_valid_r, res_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [143:0]       out_data_r;
  logic [DEL_OUT_W-1:0] del_sat;
  req_e_t             req;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign req       = req_e_t'(in_tuser);

  always_comb begin
    head          = '0;
    head.valid    = in_acc;
    head.req      = req;
    head.key      = in_tdata[31:0] & KMASK;
    head.data     = in_tdata[63:32] & DMASK;
    head.slot     = (req == REQ_PUT) ? IDX_W'(wp_r) : IDX_W'(in_tdata[67:64]);
  end

  assign chain[0] = head;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    frc_cell #(
      .KW       (KW),
      .DW       (DW),
      .CELL_IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pkt_i (chain[i]),
      .pkt_o (chain[i+1])
    );
    assign chain_v[i] = chain[i+1].valid;
  end

  assign move = res_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    wp_nxt = wp_r;
    if (in_acc) begin
      if (req == REQ_PUT) begin
        wp_nxt = (wp_r == SW'(DEPTH-1)) ? '0 : wp_r + SW'(1);
      end else if (req == REQ_CLEAR) begin
        wp_nxt = '0;
      end
    end
  end

  always_comb begin
    hit_nxt       = hit_r;
    miss_nxt      = miss_r;
    res_valid_nxt = res_valid_r && !move;
    if (chain[DEPTH].valid) begin
      res_valid_nxt = 1'b1;
      if (chain[DEPTH].req == REQ_FIND) begin
        if (chain[DEPTH].found) begin
          hit_nxt = hit_r + FLD_W'(1);
        end else begin
          miss_nxt = miss_r + FLD_W'(1);
        end
      end else if (chain[DEPTH].req == REQ_CLEAR) begin
        hit_nxt  = '0;
        miss_nxt = '0;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign del_sat = (res_r.count > CNT_W'(31)) ? DEL_OUT_W'(31) : res_r.count[DEL_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      wp_r        <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      wp_r        <= wp_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chain[DEPTH].valid) begin
      res_r <= chain[DEPTH];
    end
    if (move) begin
      out_data_r <= {6'd0, miss_r, hit_r, del_sat, res_r.key_out, res_r.data_out,
                     res_r.slot_out[SLOT_OUT_W-1:0], res_r.found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted word did not mark the block busy");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({chain_v, res_valid_r}))
    else $error("more than one word in the cell chain");

  a_wp_range : assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= SW'(DEPTH-1))
    else $error("write pointer beyond last slot");

  a_fin_free : assert property (@(posedge clk) disable iff (!rst_n)
    chain[DEPTH].valid |-> (busy_r && !res_valid_r))
    else $error("result left the chain with the hold register full");

endmodule

// ===== rtl/frc_cell.sv =====
// one slot of the cache: holds a key and a data word, acts on the passing request word
// depends on frc_pkg

module frc_cell #(
  parameter int KW       = 32,
  parameter int DW       = 32,
  parameter int CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  frc_pkg::pkt_t pkt_i,
  output frc_pkg::pkt_t pkt_o
);
  import frc_pkg::*;

  logic [KW-1:0] key_r, key_nxt;
  logic [DW-1:0] data_r, data_nxt;
  pkt_t          pkt_r, pkt_nxt;
  logic          hit_key;
  logic          hit_idx;

  assign hit_key = (pkt_i.key == FLD_W'(key_r));
  assign hit_idx = (pkt_i.slot == IDX_W'(CELL_IDX));

  always_comb begin
    pkt_nxt  = pkt_i;
    key_nxt  = key_r;
    data_nxt = data_r;
    if (pkt_i.valid) begin
      unique case (pkt_i.req)
        REQ_PUT: begin
          if (hit_idx) begin
            key_nxt          = pkt_i.key[KW-1:0];
            data_nxt         = pkt_i.data[DW-1:0];
            pkt_nxt.found    = 1'b1;
            pkt_nxt.slot_out = IDX_W'(CELL_IDX);
          end
        end
        REQ_FIND: begin
          if (!pkt_i.found && hit_key) begin
            pkt_nxt.found    = 1'b1;
            pkt_nxt.slot_out = IDX_W'(CELL_IDX);
            pkt_nxt.data_out = FLD_W'(data_r);
          end
        end
        REQ_DEL_KEY: begin
          if (hit_key) begin
            key_nxt       = '0;
            data_nxt      = '0;
            pkt_nxt.count = pkt_i.count + CNT_W'(1);
          end
        end
        REQ_DEL_SLOT: begin
          if (hit_idx) begin
            key_nxt       = '0;
            data_nxt      = '0;
            pkt_nxt.found = 1'b1;
          end
        end
        REQ_READ_KEY: begin
          if (hit_idx) begin
            pkt_nxt.key_out = FLD_W'(key_r);
            pkt_nxt.found   = 1'b1;
          end
        end
        REQ_CLEAR: begin
          key_nxt  = '0;
          data_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      data_r      <= '0;
      pkt_r.valid <= 1'b0;
    end else begin
      key_r  <= key_nxt;
      data_r <= data_nxt;
      pkt_r  <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

// ===== dv/tb_fifo_replacement_cache.sv =====
`timescale 1ns / 1ps
// self-checking testbench for fifo_replacement_cache: drives put, find, delete, read, clear and
// reserved-code requests and checks every result against a built-in model of the slot store
// depends on frc_pkg and the fifo_replacement_cache rtl

module tb_fifo_replacement_cache;
  import frc_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 334;
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic [31:0] data;
    logic [31:0] key;
    logic [4:0]  deleted;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_result_t;

  class cache_scoreboard;
    logic [31:0]    key_mem[DEPTH];
    logic [31:0]    data_mem[DEPTH];
    logic [3:0]     wr_ptr;
    logic [31:0]    hit_count;
    logic [31:0]    miss_count;
    lookup_result_t pending_results[$];
    int             mismatches;
    int             checked;

    function new();
      clear_store();
      mismatches = 0;
      checked = 0;
    endfunction

    function void clear_store();
      for (int i = 0; i < DEPTH; i++) begin
        key_mem[i] = '0;
        data_mem[i] = '0;
      end
      wr_ptr = '0;
      hit_count = '0;
      miss_count = '0;
    endfunction

    function void note_request(logic [2:0] req, logic [31:0] key, logic [31:0] data,
                               logic [3:0] slot);
      lookup_result_t r;
      int cnt;
      r = '0;
      cnt = 0;
      case (req)
        REQ_PUT: begin
          key_mem[wr_ptr] = key;
          data_mem[wr_ptr] = data;
          r.found = 1'b1;
          r.slot = wr_ptr;
          wr_ptr = (int'(wr_ptr) + 1 >= DEPTH) ? '0 : wr_ptr + 4'd1;
        end
        REQ_FIND: begin
          for (int i = 0; i < DEPTH; i++)
            if (!r.found && key_mem[i] == key) begin
              r.found = 1'b1;
              r.slot = 4'(i);
              r.data = data_mem[i];
            end
          if (r.found) hit_count++;
          else miss_count++;
        end
        REQ_DEL_KEY: begin
          for (int i = 0; i < DEPTH; i++)
            if (key_mem[i] == key) begin
              key_mem[i] = '0;
              data_mem[i] = '0;
              cnt++;
            end
          r.deleted = 5'((cnt > 31) ? 31 : cnt);
        end
        REQ_DEL_SLOT: begin
          if (int'(slot) < DEPTH) begin
            key_mem[slot] = '0;
            data_mem[slot] = '0;
            r.found = 1'b1;
          end
        end
        REQ_READ_KEY: begin
          if (int'(slot) < DEPTH) begin
            r.key = key_mem[slot];
            r.found = 1'b1;
          end
        end
        REQ_CLEAR: clear_store();
        default: ;
      endcase
      r.hits = hit_count;
      r.misses = miss_count;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("slot_out", 32'(want.slot), 32'(got.slot));
      compare_field("data_out", want.data, got.data);
      compare_field("key_out", want.key, got.key);
      compare_field("deleted_count", 32'(want.deleted), 32'(got.deleted));
      compare_field("hit_total", want.hits, got.hits);
      compare_field("miss_total", want.misses, got.misses);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  cache_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int request_count = 0;
  logic [31:0] key_pool[8];

  fifo_replacement_cache #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(32),
    .DATA_WIDTH(32)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    lookup_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tdata[0];
      got.slot = out_tdata[4:1];
      got.data = out_tdata[36:5];
      got.key = out_tdata[68:37];
      got.deleted = out_tdata[73:69];
      got.hits = out_tdata[105:74];
      got.misses = out_tdata[137:106];
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, sb.pending_results.size());
      $display("** fifo_replacement_cache: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [31:0] key,
                              input logic [31:0] data, input logic [3:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0, slot, data, key};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, key, data, slot);
    request_count++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int roll;
    logic [2:0] req;
    logic [31:0] key;
    roll = $urandom_range(99);
    if (roll < 30) req = REQ_PUT;
    else if (roll < 58) req = REQ_FIND;
    else if (roll < 68) req = REQ_DEL_KEY;
    else if (roll < 78) req = REQ_DEL_SLOT;
    else if (roll < 90) req = REQ_READ_KEY;
    else if (roll < 93) req = REQ_CLEAR;
    else if (roll < 96) req = REQ_RSVD_6;
    else req = REQ_RSVD_7;
    key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom();
    send_request(req, key, $urandom(), 4'($urandom_range(15)));
  endtask

  initial begin
    for (int i = 0; i < 7; i++) key_pool[i] = $urandom();
    key_pool[7] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero key on empty store, extremes, duplicates, reserved codes, clear
    send_request(REQ_FIND, 32'h0, 32'h0, 4'd0);
    send_request(REQ_READ_KEY, 32'h0, 32'h0, 4'd15);
    send_request(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
    send_request(REQ_PUT, 32'h1234_5678, 32'h0, 4'd0);
    send_request(REQ_FIND, 32'hffff_ffff, 32'h0, 4'd0);
    send_request(REQ_FIND, 32'hdead_beef, 32'h0, 4'd0);
    send_request(REQ_FIND, 32'h0, 32'h0, 4'd0);
    send_request(REQ_DEL_KEY, 32'h0, 32'h0, 4'd0);
    send_request(REQ_READ_KEY, 32'h0, 32'h0, 4'd0);
    send_request(REQ_DEL_SLOT, 32'h0, 32'h0, 4'd0);
    send_request(REQ_READ_KEY, 32'h0, 32'h0, 4'd0);
    repeat (3) send_request(REQ_PUT, 32'h0000_00a5, 32'h5a5a_5a5a, 4'd0);
    send_request(REQ_FIND, 32'h0000_00a5, 32'h0, 4'd0);
    send_request(REQ_DEL_KEY, 32'h0000_00a5, 32'h0, 4'd0);
    send_request(REQ_RSVD_6, 32'haaaa_aaaa, 32'h5555_5555, 4'd10);
    send_request(REQ_RSVD_7, 32'h5555_5555, 32'haaaa_aaaa, 4'd5);
    send_request(REQ_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
    send_request(REQ_FIND, 32'h0, 32'h0, 4'd0);
    send_request(REQ_DEL_KEY, 32'h0, 32'h0, 4'd0);
    send_request(REQ_READ_KEY, 32'h0, 32'h0, 4'd15);
    send_request(REQ_DEL_SLOT, 32'h0, 32'h0, 4'd15);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 128 == 127) key_pool[$urandom_range(6)] = $urandom();
        if (phase == 0 && n == RANDOM_PER_PHASE / 2) drain();
        random_request();
      end
    end

    drain();
    repeat (DEPTH + 4) @(posedge clk);
    $display("run covered %0d requests with %0d result words checked", request_count,
             sb.checked);
    $display("finds: %0d hits, %0d misses; mismatches: %0d", sb.hit_count, sb.miss_count,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("** fifo_replacement_cache: PASSED **");
    end else begin
      $display("** fifo_replacement_cache: FAILED **");
    end
    $finish;
  end

endmodule
